@@ hw/rtl/http_request_line_parser_unit_macros.svh @@
// Assertion macros used by the request line parser RTL.
// Each macro takes a label, the clock, the reset, the property terms and a message.
`ifndef HTTP_REQUEST_LINE_PARSER_UNIT_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Plain property that must hold at every edge outside reset
`define HTTP_RLP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define HTTP_RLP_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define HTTP_RLP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define HTTP_RLP_ASSERT(lbl, clk, rst, prop, msg)
`define HTTP_RLP_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define HTTP_RLP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ hw/rtl/http_rlp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package http_rlp_pkg;

   // Parse phases
   typedef enum logic [2:0] {
      PH_METHOD  = 3'd0,
      PH_GAP     = 3'd1,
      PH_URL     = 3'd2,
      PH_VERSION = 3'd3,
      PH_HEADER  = 3'd4,
      PH_OK      = 3'd5,
      PH_BAD     = 3'd6
   } phase_type;

   // URL scan modes
   typedef enum logic [1:0] {
      UM_UNDEC  = 2'd0,
      UM_PREFIX = 2'd1,
      UM_SEEK   = 2'd2,
      UM_PATH   = 2'd3
   } url_mode_type;

   // Header line modes
   typedef enum logic [1:0] {
      HM_NAME  = 2'd0,
      HM_SKIP  = 2'd1,
      HM_VALUE = 2'd2,
      HM_OTHER = 2'd3
   } header_mode_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_MORE = 2'd0,
      ST_DONE = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   // Parser state carried from byte to byte
   typedef struct packed {
      phase_type       phase;
      logic [3:0]      match_index;
      logic            token_matching;
      url_mode_type    url_mode;
      header_mode_type header_mode;
      logic            pending_bad;
      logic            carriage_seen;
      logic            line_is_empty;
   } state_type;

   // Marks and verdict for one byte
   typedef struct packed {
      status_type status;
      logic       url_byte;
      logic       host_byte;
      logic       line_end;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:          PH_METHOD,
      match_index:    4'd0,
      token_matching: 1'b1,
      url_mode:       UM_UNDEC,
      header_mode:    HM_NAME,
      pending_bad:    1'b0,
      carriage_seen:  1'b0,
      line_is_empty:  1'b1
   };

   localparam int DATA_W  = 8;
   localparam int TDATA_W = 16;

endpackage

`default_nettype wire

@@ hw/rtl/http_rlp_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module http_rlp_step (
   input  wire  logic [7:0]              data_byte,
   input  wire  logic                    first_of_message,
   input  wire  http_rlp_pkg::state_type state_cur,
   output http_rlp_pkg::state_type       state_nxt,
   output http_rlp_pkg::result_type      result
);
   import http_rlp_pkg::*;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_H     = 8'h68;

   typedef struct packed {
      state_type st;
      logic      ub;
   } url_res_type;

   function automatic logic [7:0] lower_of(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) r = b + 8'd32;
      return r;
   endfunction

   function automatic logic is_delim(input logic [7:0] b);
      return (b == CH_SP) || (b == CH_TAB);
   endfunction

   function automatic logic [7:0] get_char(input logic [3:0] i);
      logic [7:0] c;
      case (i)
         4'd0:    c = "g";
         4'd1:    c = "e";
         4'd2:    c = "t";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] ver_char(input logic [3:0] i);
      logic [7:0] c;
      case (i)
         4'd0:    c = "h";
         4'd1:    c = "t";
         4'd2:    c = "t";
         4'd3:    c = "p";
         4'd4:    c = "/";
         4'd5:    c = "1";
         4'd6:    c = ".";
         4'd7:    c = "1";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] pfx_char(input logic [3:0] i);
      logic [7:0] c;
      case (i)
         4'd0:    c = "h";
         4'd1:    c = "t";
         4'd2:    c = "t";
         4'd3:    c = "p";
         4'd4:    c = ":";
         4'd5:    c = "/";
         4'd6:    c = "/";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] host_char(input logic [3:0] i);
      logic [7:0] c;
      case (i)
         4'd0:    c = "h";
         4'd1:    c = "o";
         4'd2:    c = "s";
         4'd3:    c = "t";
         4'd4:    c = ":";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Advance a literal token match by one byte, or drop the match
   function automatic state_type token_step(input state_type s, input logic [7:0] b,
                                            input logic [7:0] ch, input logic [3:0] len);
      state_type r;
      r = s;
      if (s.token_matching && s.match_index < len && lower_of(b) == ch)
         r.match_index = s.match_index + 4'd1;
      else
         r.token_matching = 1'b0;
      return r;
   endfunction

   // Classify one non-delimiter URL byte
   function automatic url_res_type url_step(input state_type s, input logic [7:0] b);
      url_res_type r;
      logic [3:0]  inc;
      r.st = s;
      r.ub = 1'b0;
      inc  = s.match_index + 4'd1;
      case (s.url_mode)
         UM_UNDEC: begin
            if (b == CH_SLASH) begin
               r.st.url_mode = UM_PATH;
               r.ub          = 1'b1;
            end else if (lower_of(b) == CH_H) begin
               r.st.url_mode    = UM_PREFIX;
               r.st.match_index = 4'd1;
            end else begin
               r.st.token_matching = 1'b0;
               r.st.url_mode       = UM_SEEK;
            end
         end
         UM_PREFIX: begin
            if (s.match_index < 4'd7 && lower_of(b) == pfx_char(s.match_index)) begin
               r.st.match_index = inc;
               if (inc == 4'd7) r.st.url_mode = UM_SEEK;
            end else begin
               r.st.token_matching = 1'b0;
               r.st.url_mode       = UM_SEEK;
            end
         end
         UM_SEEK: begin
            if (s.token_matching && b == CH_SLASH) begin
               r.st.url_mode = UM_PATH;
               r.ub          = 1'b1;
            end
         end
         default: r.ub = 1'b1;
      endcase
      return r;
   endfunction

   state_type   cur;
   url_res_type ures;
   logic [3:0]  hinc;

   // Work out next state and marks for this byte
   always_comb begin
      cur              = first_of_message ? STATE_RESET : state_cur;
      state_nxt        = cur;
      result.status    = ST_MORE;
      result.url_byte  = 1'b0;
      result.host_byte = 1'b0;
      result.line_end  = 1'b0;
      ures             = '0;
      hinc             = cur.match_index + 4'd1;

      if (cur.phase == PH_OK) begin
         result.status = ST_DONE;
      end else if (cur.phase == PH_BAD) begin
         result.status = ST_BAD;
      end else if (cur.carriage_seen) begin
         state_nxt.carriage_seen = 1'b0;
         if (data_byte != CH_LF) begin
            state_nxt.phase = PH_BAD;
            result.status   = ST_BAD;
         end else if (cur.phase == PH_HEADER) begin
            result.line_end = 1'b1;
            if (cur.line_is_empty) begin
               state_nxt.phase = PH_OK;
               result.status   = ST_DONE;
            end else begin
               state_nxt.header_mode   = HM_NAME;
               state_nxt.match_index   = 4'd0;
               state_nxt.line_is_empty = 1'b1;
            end
         end else begin
            result.line_end = 1'b1;
            if (cur.phase == PH_VERSION && cur.token_matching && cur.match_index == 4'd8 &&
                !cur.pending_bad) begin
               state_nxt.phase         = PH_HEADER;
               state_nxt.header_mode   = HM_NAME;
               state_nxt.match_index   = 4'd0;
               state_nxt.line_is_empty = 1'b1;
            end else begin
               state_nxt.phase = PH_BAD;
               result.status   = ST_BAD;
            end
         end
      end else if (data_byte == CH_CR) begin
         state_nxt.carriage_seen = 1'b1;
      end else if (data_byte == CH_LF) begin
         state_nxt.phase = PH_BAD;
         result.status   = ST_BAD;
      end else begin
         state_nxt.line_is_empty = 1'b0;
         case (cur.phase)
            PH_METHOD: begin
               if (is_delim(data_byte)) begin
                  if (!(cur.token_matching && cur.match_index == 4'd3))
                     state_nxt.pending_bad = 1'b1;
                  state_nxt.phase = PH_GAP;
               end else begin
                  state_nxt = token_step(state_nxt, data_byte,
                                         get_char(cur.match_index), 4'd3);
               end
            end
            PH_GAP: begin
               if (!is_delim(data_byte)) begin
                  state_nxt.phase          = PH_URL;
                  state_nxt.url_mode       = UM_UNDEC;
                  state_nxt.token_matching = 1'b1;
                  state_nxt.match_index    = 4'd0;
                  ures                     = url_step(state_nxt, data_byte);
                  state_nxt                = ures.st;
                  result.url_byte          = ures.ub;
               end
            end
            PH_URL: begin
               if (is_delim(data_byte)) begin
                  if (!(cur.token_matching && cur.url_mode == UM_PATH))
                     state_nxt.pending_bad = 1'b1;
                  state_nxt.phase          = PH_VERSION;
                  state_nxt.match_index    = 4'd0;
                  state_nxt.token_matching = 1'b1;
               end else begin
                  ures            = url_step(state_nxt, data_byte);
                  state_nxt       = ures.st;
                  result.url_byte = ures.ub;
               end
            end
            PH_VERSION: begin
               state_nxt = token_step(state_nxt, data_byte,
                                      ver_char(cur.match_index), 4'd8);
            end
            PH_HEADER: begin
               case (cur.header_mode)
                  HM_NAME: begin
                     if (cur.match_index < 4'd5 &&
                         lower_of(data_byte) == host_char(cur.match_index)) begin
                        state_nxt.match_index = hinc;
                        if (hinc == 4'd5) state_nxt.header_mode = HM_SKIP;
                     end else begin
                        state_nxt.header_mode = HM_OTHER;
                     end
                  end
                  HM_SKIP: begin
                     if (!is_delim(data_byte)) begin
                        state_nxt.header_mode = HM_VALUE;
                        result.host_byte      = 1'b1;
                     end
                  end
                  HM_VALUE: result.host_byte = 1'b1;
                  default:  result.host_byte = 1'b0;
               endcase
            end
            default: begin
               state_nxt.phase = PH_BAD;
               result.status   = ST_BAD;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/http_request_line_parser_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Ports                  Contents
// req      in   req_tvalid/tready      tdata[7:0] data_byte, tuser first_of_message
// rsp      out  rsp_tvalid/tready      tdata[7:0] data_out, [9:8] status; tuser url, host;
//                                      tlast line_end
//
// One byte per cycle sustained while rsp is ready; a byte reaches rsp through the input
// register and then the result register. The byte decode and state update sit between
// the two registers and are combinational. Synchronous reset returns the parser to the
// method phase and empties both registers. A stalled rsp holds its result while one more
// byte is taken into the input register; req_tready drops only when both are full.

`include "http_request_line_parser_unit_macros.svh"

module http_request_line_parser_unit (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_tvalid,
   output logic              req_tready,
   input  wire  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire  logic        req_tuser,   // [0] first_of_message
   output logic              rsp_tvalid,
   input  wire  logic        rsp_tready,
   output logic [15:0]       rsp_tdata,   // [7:0] data_out, [9:8] status, [15:10] zero
   output logic [1:0]        rsp_tuser,   // [0] url_byte, [1] host_byte
   output logic              rsp_tlast    // line_end
);
   import http_rlp_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_first_ff;
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   result_type  out_res_ff;
   state_type   state_ff;
   state_type   state_in;
   result_type  res_in;
   logic        out_free;
   logic        in_move;

   // Stage handshake
   assign out_free   = !out_valid_ff || rsp_tready;
   assign in_move    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || in_move;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
      end
   end

   http_rlp_step u_step (
      .data_byte        (in_byte_ff),
      .first_of_message (in_first_ff),
      .state_cur        (state_ff),
      .state_nxt        (state_in),
      .result           (res_in)
   );

   // Parser state advances with each byte that moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (in_move) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
      if (in_move) begin
         out_byte_ff <= in_byte_ff;
         out_res_ff  <= res_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(TDATA_W - DATA_W - 2)'(0), out_res_ff.status, out_byte_ff};
   assign rsp_tuser  = {out_res_ff.host_byte, out_res_ff.url_byte};
   assign rsp_tlast  = out_res_ff.line_end;

   // Checks
   `HTTP_RLP_ASSERT_IMPLY(a_bad_no_marks, clock, reset,
      out_valid_ff && out_res_ff.status == ST_BAD,
      !out_res_ff.url_byte && !out_res_ff.host_byte, "bad verdict carries a mark")
   `HTTP_RLP_ASSERT_NEXT(a_done_sticky, clock, reset,
      in_move && state_ff.phase == PH_OK && !in_first_ff,
      out_res_ff.status == ST_DONE, "complete verdict not repeated")
   `HTTP_RLP_ASSERT_IMPLY(a_cr_live_phase, clock, reset,
      state_ff.carriage_seen, state_ff.phase != PH_OK && state_ff.phase != PH_BAD,
      "pending CR in a finished request")
   `HTTP_RLP_ASSERT_IMPLY(a_ready_when_free, clock, reset,
      !out_valid_ff, req_tready, "input stalled with free result register")

endmodule

`default_nettype wire
